// ----- hw/rtl/tcrs_pkg.sv -----
// Package for the touch contact risk scorer: field types, register
// indexes and scoring constants. No dependencies.

package tcrs_pkg;

   typedef logic signed [15:0] coord_type;
   typedef logic [31:0]        dur_type;
   typedef logic [15:0]        path_type;
   typedef logic [14:0]        major_base_type;
   typedef logic [6:0]         score_type;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_BOUNDS_KNOWN = 3'd0,
      REG_BOUND_X_MIN  = 3'd1,
      REG_BOUND_X_MAX  = 3'd2,
      REG_BOUND_Y_MIN  = 3'd3,
      REG_BOUND_Y_MAX  = 3'd4
   } csr_index_type;

   // evidence bit positions
   localparam int EV_FAST  = 0;
   localparam int EV_EDGE  = 1;
   localparam int EV_SHORT = 2;
   localparam int EV_BURST = 3;
   localparam int EV_MAJOR = 4;

   // family bit positions
   localparam int FAM_TIMING   = 0;
   localparam int FAM_SPATIAL  = 1;
   localparam int FAM_MOTION   = 2;
   localparam int FAM_GEOMETRY = 3;

   localparam logic [31:0] DUR_FAST_MAX = 32'd5000;
   localparam logic [31:0] DUR_SLOW_MAX = 32'd8000;
   localparam logic [6:0]  PTS_DUR_ZERO = 7'd35;
   localparam logic [6:0]  PTS_DUR_FAST = 7'd70;
   localparam logic [6:0]  PTS_DUR_SLOW = 7'd42;

   localparam logic signed [16:0] EDGE_NEAR_MAX  = 17'sd3;
   localparam logic signed [16:0] EDGE_CLOSE_MAX = 17'sd10;
   localparam logic [5:0]         PTS_EDGE_NEAR  = 6'd42;
   localparam logic [5:0]         PTS_EDGE_CLOSE = 6'd16;

   localparam logic [15:0] BASE_MIN_SAMPLES = 16'd20;
   localparam logic [7:0]  PTS_SHORT        = 8'd24;
   localparam logic [7:0]  PTS_BURST        = 8'd18;
   localparam logic [7:0]  PTS_MAJOR        = 8'd10;

   localparam logic [7:0] SCORE_MAX   = 8'd100;
   localparam logic [6:0] SUSPECT_MIN = 7'd65;
   localparam logic [6:0] DROP_MIN    = 7'd85;

   // per-contact score parts from the compare logic
   typedef struct packed {
      logic [6:0] dur_pts;
      logic [5:0] edge_pts;
      logic [4:0] evidence;
   } score_parts_type;

endpackage

// ----- hw/rtl/touch_contact_risk_scorer.sv -----
// Touch contact risk scorer top level: input register, compare and score
// logic, result register, APB register file. Depends on tcrs_pkg.

// One contact is accepted per cycle (busy is always low) and its result is
// strobed on the rsp_ ports after passing the input register and then the
// result register. The receiver cannot stall, so nothing holds the pipeline:
// the scoring logic sits between the input register and the result register.
// A contact without a position still gives a result, with every field zero.
// Panel bounds are read at 0x04..0x10; write them only while no contact
// is in flight.

module touch_contact_risk_scorer (
   input  logic                                clock,
   input  logic                                reset,
   // command channel
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_position_valid,
   input  tcrs_pkg::coord_type                 req_coord_x,
   input  tcrs_pkg::coord_type                 req_coord_y,
   input  tcrs_pkg::dur_type                   req_contact_duration,
   input  tcrs_pkg::path_type                  req_path_length,
   input  tcrs_pkg::coord_type                 req_major_axis,
   input  tcrs_pkg::path_type                  req_baseline_samples,
   input  tcrs_pkg::dur_type                   req_baseline_duration,
   input  tcrs_pkg::path_type                  req_baseline_path,
   input  tcrs_pkg::major_base_type            req_baseline_major,
   // result channel
   output logic                                rsp_strobe,
   output tcrs_pkg::score_type                 rsp_risk_score,
   output logic [4:0]                          rsp_evidence_bits,
   output logic [3:0]                          rsp_family_bits,
   output logic [2:0]                          rsp_family_total,
   output logic                                rsp_is_suspect,
   output logic                                rsp_should_drop,
   // APB register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tcrs_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [tcrs_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [tcrs_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   import tcrs_pkg::*;

   // ---------------- registers ----------------
   logic      bounds_known_ff;
   coord_type bound_x_min_ff, bound_x_max_ff, bound_y_min_ff, bound_y_max_ff;

   logic csr_write;
   csr_index_type csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_index = csr_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         bounds_known_ff <= 1'b0;
         bound_x_min_ff  <= '0;
         bound_x_max_ff  <= '0;
         bound_y_min_ff  <= '0;
         bound_y_max_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_BOUNDS_KNOWN: bounds_known_ff <= pwdata[0];
            REG_BOUND_X_MIN:  bound_x_min_ff  <= pwdata[15:0];
            REG_BOUND_X_MAX:  bound_x_max_ff  <= pwdata[15:0];
            REG_BOUND_Y_MIN:  bound_y_min_ff  <= pwdata[15:0];
            REG_BOUND_Y_MAX:  bound_y_max_ff  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_BOUNDS_KNOWN: prdata = {31'd0, bounds_known_ff};
         REG_BOUND_X_MIN:  prdata = 32'(bound_x_min_ff);
         REG_BOUND_X_MAX:  prdata = 32'(bound_x_max_ff);
         REG_BOUND_Y_MIN:  prdata = 32'(bound_y_min_ff);
         REG_BOUND_Y_MAX:  prdata = 32'(bound_y_max_ff);
         default:          prdata = '0;
      endcase
   end

   // ---------------- input register ----------------
   assign busy = 1'b0;

   logic           req_valid_ff;
   logic           pos_valid_ff;
   coord_type      x_ff, y_ff, major_ff;
   dur_type        dur_ff, avg_dur_ff;
   path_type       path_ff, samples_ff, avg_path_ff;
   major_base_type avg_major_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start & ~busy;
      end
      if (start & ~busy) begin
         pos_valid_ff <= req_position_valid;
         x_ff         <= req_coord_x;
         y_ff         <= req_coord_y;
         dur_ff       <= req_contact_duration;
         path_ff      <= req_path_length;
         major_ff     <= req_major_axis;
         samples_ff   <= req_baseline_samples;
         avg_dur_ff   <= req_baseline_duration;
         avg_path_ff  <= req_baseline_path;
         avg_major_ff <= req_baseline_major;
      end
   end

   // ---------------- compares ----------------
   logic              dur_zero, dur_fast, dur_slow;
   logic signed [16:0] x17, y17, d_xl, d_xh, d_yl, d_yh, d_a, d_b, edge_dist;
   logic              edge_near, edge_close;
   logic              base_ok, short_hit, burst_hit, major_hit;
   logic [34:0]       dur_x6_p6;
   logic [33:0]       dur_x2_p2;
   logic [14:0]       major_mag;
   logic [17:0]       major_x5, avg_major_x5;
   score_parts_type   parts_in;

   always_comb begin
      dur_zero = (dur_ff == '0);
      dur_fast = (dur_ff <= DUR_FAST_MAX);
      dur_slow = (dur_ff <= DUR_SLOW_MAX);

      x17 = 17'(x_ff);
      y17 = 17'(y_ff);
      if (bounds_known_ff) begin
         d_xl = x17 - 17'(bound_x_min_ff);
         d_xh = 17'(bound_x_max_ff) - x17;
         d_yl = y17 - 17'(bound_y_min_ff);
         d_yh = 17'(bound_y_max_ff) - y17;
      end else begin
         // no bounds: distance to the origin axes only
         d_xl = x_ff[15] ? 17'sd0 : x17;
         d_xh = d_xl;
         d_yl = y_ff[15] ? 17'sd0 : y17;
         d_yh = d_yl;
      end
      d_a = (d_xl < d_xh) ? d_xl : d_xh;
      d_b = (d_yl < d_yh) ? d_yl : d_yh;
      edge_dist  = (d_a < d_b) ? d_a : d_b;
      // a negative distance (outside the bounds) lies inside the near band anyway
      edge_near  = (edge_dist <= EDGE_NEAR_MAX);
      edge_close = (edge_dist <= EDGE_CLOSE_MAX);

      base_ok = (samples_ff >= BASE_MIN_SAMPLES);

      // dur < avg/6  <=>  avg >= 6*dur + 6
      dur_x6_p6 = {1'b0, dur_ff, 2'b00} + {2'b00, dur_ff, 1'b0} + 35'd6;
      short_hit = base_ok && (avg_dur_ff != '0) && !dur_zero &&
                  ({3'b000, avg_dur_ff} >= dur_x6_p6);

      // dur < avg/2  <=>  avg >= 2*dur + 2
      dur_x2_p2 = {1'b0, dur_ff, 1'b0} + 34'd2;
      burst_hit = base_ok && (avg_path_ff != '0) &&
                  ({3'b000, path_ff} > {avg_path_ff, 3'b000}) &&
                  (avg_dur_ff != '0) && ({2'b00, avg_dur_ff} >= dur_x2_p2);

      major_mag    = major_ff[14:0];
      major_x5     = {1'b0, major_mag, 2'b00} + {3'b000, major_mag};
      avg_major_x5 = {1'b0, avg_major_ff, 2'b00} + {3'b000, avg_major_ff};
      major_hit = base_ok && !major_ff[15] && (avg_major_ff >= 15'd2) &&
                  ((major_x5 < {3'b000, avg_major_ff}) ||
                   ({3'b000, major_mag} > avg_major_x5));

      if (dur_zero)      parts_in.dur_pts = PTS_DUR_ZERO;
      else if (dur_fast) parts_in.dur_pts = PTS_DUR_FAST;
      else if (dur_slow) parts_in.dur_pts = PTS_DUR_SLOW;
      else               parts_in.dur_pts = '0;

      if (edge_near)       parts_in.edge_pts = PTS_EDGE_NEAR;
      else if (edge_close) parts_in.edge_pts = PTS_EDGE_CLOSE;
      else                 parts_in.edge_pts = '0;

      parts_in.evidence           = '0;
      parts_in.evidence[EV_FAST]  = dur_slow;
      parts_in.evidence[EV_EDGE]  = edge_close;
      parts_in.evidence[EV_SHORT] = short_hit;
      parts_in.evidence[EV_BURST] = burst_hit;
      parts_in.evidence[EV_MAJOR] = major_hit;

      if (!pos_valid_ff) parts_in = '0;
   end

   // ---------------- score and flags ----------------
   logic [7:0] score_sum;
   logic [6:0] score_in;
   logic [3:0] family_in;
   logic [2:0] family_total_in;
   logic       two_families;

   always_comb begin
      score_sum = {1'b0, parts_in.dur_pts} + {2'b00, parts_in.edge_pts}
                + (parts_in.evidence[EV_SHORT] ? PTS_SHORT : 8'd0)
                + (parts_in.evidence[EV_BURST] ? PTS_BURST : 8'd0)
                + (parts_in.evidence[EV_MAJOR] ? PTS_MAJOR : 8'd0);
      score_in = (score_sum > SCORE_MAX) ? SCORE_MAX[6:0] : score_sum[6:0];

      family_in[FAM_TIMING]   = parts_in.evidence[EV_FAST] | parts_in.evidence[EV_SHORT];
      family_in[FAM_SPATIAL]  = parts_in.evidence[EV_EDGE];
      family_in[FAM_MOTION]   = parts_in.evidence[EV_BURST];
      family_in[FAM_GEOMETRY] = parts_in.evidence[EV_MAJOR];
      family_total_in = {2'b00, family_in[0]} + {2'b00, family_in[1]}
                      + {2'b00, family_in[2]} + {2'b00, family_in[3]};
      two_families = (family_total_in >= 3'd2);
   end

   logic       rsp_strobe_ff;
   score_type  rsp_score_ff;
   logic [4:0] rsp_evidence_ff;
   logic [3:0] rsp_family_ff;
   logic [2:0] rsp_total_ff;
   logic       rsp_suspect_ff, rsp_drop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= req_valid_ff;
      end
      rsp_score_ff    <= score_in;
      rsp_evidence_ff <= parts_in.evidence;
      rsp_family_ff   <= family_in;
      rsp_total_ff    <= family_total_in;
      rsp_suspect_ff  <= two_families && (score_in >= SUSPECT_MIN);
      rsp_drop_ff     <= two_families && (score_in >= DROP_MIN);
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_risk_score    = rsp_score_ff;
   assign rsp_evidence_bits = rsp_evidence_ff;
   assign rsp_family_bits   = rsp_family_ff;
   assign rsp_family_total  = rsp_total_ff;
   assign rsp_is_suspect    = rsp_suspect_ff;
   assign rsp_should_drop   = rsp_drop_ff;

   // ---------------- assertions ----------------
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##2 rsp_strobe)
      else $error("result word not strobed two cycles after start");

   a_score_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_risk_score <= SCORE_MAX[6:0]))
      else $error("risk score above saturation limit");

   a_score_has_evidence: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_risk_score != '0) |-> (rsp_evidence_bits != '0))
      else $error("nonzero score without evidence");

   a_drop_implies_suspect: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_should_drop) |-> rsp_is_suspect)
      else $error("drop flagged without suspect");

endmodule
